### rtl/tcw_pkg.sv
// Shared types, character codes and helpers of the text console writer.
`default_nettype none

package tcw_pkg;

  // Field widths that the interface fixes.
  localparam int unsigned CH_W     = 8;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned PROMPT_W = 7;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // Operation codes of a request.
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Character codes with a meaning of their own.
  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CH_W-1:0] CH_BLANK     = 8'h20;

  // Configuration register indexes and reset values.
  localparam logic                REG_PROMPT   = 1'b0;
  localparam logic [PROMPT_W-1:0] PROMPT_RESET = 7'd14;

  // One request on the input channel.
  typedef struct packed {
    logic             func;
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] cell_index;
  } tcw_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic [CH_W-1:0]  cell_char;
    logic             scrolled;
  } tcw_rsp_t;

  // Status that the cursor unit hands to the sequencer.
  typedef struct packed {
    logic             cell_we;
    logic [CH_W-1:0]  cell_data;
    logic             scroll;
    logic [POS_W-1:0] position;
  } tcw_cur_sts_t;

  // Clamp a widened sum back into the signed 16-bit range.
  function automatic logic signed [CNT_W-1:0] sat16(input logic signed [CNT_W+1:0] v);
    logic signed [CNT_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/tcw_apb.sv
// APB configuration register file of the text console writer.
`default_nettype none

module tcw_apb import tcw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,
  output logic      [PROMPT_W-1:0] prompt_o
);

  logic                reg_idx;
  logic                wr_en;
  logic [PROMPT_W-1:0] prompt_q;

  // Registers are word aligned; the byte offset is ignored.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Prompt length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_q <= PROMPT_RESET;
    end else if (wr_en && (reg_idx == REG_PROMPT)) begin
      prompt_q <= pwdata[PROMPT_W-1:0];
    end
  end

  // Read decoder.
  always_comb begin
    unique case (reg_idx)
      REG_PROMPT: prdata = APB_DW'(prompt_q);
      default:    prdata = '0;
    endcase
  end

  assign prompt_o = prompt_q;

endmodule

`default_nettype wire

### rtl/tcw_cursor.sv
// Cursor, protected-line mark and wrap counter, with the per-character update.
`default_nettype none

module tcw_cursor import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  localparam int unsigned ADDR_W = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                apply_i,
  input  wire logic [CH_W-1:0]     ch_i,
  input  wire logic [PROMPT_W-1:0] prompt_i,
  output logic      [ADDR_W-1:0]   wr_addr_o,
  output tcw_cur_sts_t             sts_o
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);

  logic [COL_W-1:0]        col_q, col_d, col_sel;
  logic [ROW_W-1:0]        row_q, row_d, row_sel;
  logic signed [CNT_W-1:0] prot_q, prot_d, prot_mid;
  logic signed [CNT_W-1:0] wrap_q, wrap_d;
  logic signed [CNT_W:0]   row_s, prot_s;
  logic                    is_nl, is_bs, may_erase, advance, scroll;
  logic                    cell_we;
  logic [CH_W-1:0]         cell_data;
  logic [ADDR_W-1:0]       pos_addr;

  assign is_nl = (ch_i == CH_NEWLINE);
  assign is_bs = (ch_i == CH_BACKSPACE);

  // Backspace may erase only below the protected line or past the prompt on it.
  assign row_s     = $signed({1'b0, CNT_W'(row_q)});
  assign prot_s    = {prot_q[CNT_W-1], prot_q};
  assign may_erase = (row_s > prot_s) ||
                     ((row_s == prot_s) && ((COL_W+1)'(col_q) > (COL_W+1)'(prompt_i)));

  // Next cursor and counter values for the pending character.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    prot_mid  = prot_q;
    prot_d    = prot_q;
    wrap_d    = wrap_q;
    advance   = 1'b0;
    cell_we   = 1'b0;
    cell_data = CH_BLANK;
    if (is_nl) begin
      col_d   = '0;
      advance = 1'b1;
      if (wrap_q > 16'sd0) begin
        prot_mid = sat16(18'(prot_q) + 18'(wrap_q) + 18'sd1);
        wrap_d   = '0;
      end else begin
        prot_mid = sat16(18'(prot_q) + 18'sd1);
      end
    end else if (is_bs) begin
      if (may_erase) begin
        cell_we = 1'b1;
        if (col_q != '0) begin
          col_d = col_q - COL_W'(1);
        end else if (row_q != '0) begin
          row_d  = row_q - ROW_W'(1);
          col_d  = COL_W'(COLUMNS - 1);
          wrap_d = sat16(18'(wrap_q) - 18'sd1);
        end
      end
    end else begin
      cell_we   = 1'b1;
      cell_data = ch_i;
      if (col_q == COL_W'(COLUMNS - 1)) begin
        col_d   = '0;
        advance = 1'b1;
        wrap_d  = sat16(18'(wrap_q) + 18'sd1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end

    // Stepping past the last row scrolls and lowers the protected mark.
    scroll = advance && (row_q == ROW_W'(ROWS - 1));
    if (scroll) begin
      prot_d = sat16(18'(prot_mid) - 18'sd1);
    end else begin
      prot_d = prot_mid;
      if (advance) begin
        row_d = row_q + ROW_W'(1);
      end
    end

    // A put writes at the old cursor, a backspace blanks at the new one.
    col_sel = is_bs ? col_d : col_q;
    row_sel = is_bs ? row_d : row_q;
  end

  // Cell address of the write and linear cursor position.
  assign wr_addr_o = ADDR_W'(row_sel) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
  assign pos_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

  always_comb begin
    sts_o.cell_we   = cell_we;
    sts_o.cell_data = cell_data;
    sts_o.scroll    = scroll;
    sts_o.position  = POS_W'(pos_addr);
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      prot_q <= '0;
      wrap_q <= '0;
    end else if (apply_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      prot_q <= prot_d;
      wrap_q <= wrap_d;
    end
  end

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS) else $error("cursor row beyond the screen");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS) else $error("cursor column beyond the screen");

  a_scroll_keeps_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply_i && scroll) |=> (row_q == ROW_W'(ROWS - 1)))
    else $error("scroll did not leave the cursor on the last row");

endmodule

`default_nettype wire

### rtl/text_console_writer.sv
// Top level of the text console writer: request sequencer around the screen RAM.
//
//   Port group     Direction  Handshake        Contents
//   in_*           in         valid/ready      tcw_req_t: func, ch, cell_index
//   out_*          out        valid/ready      tcw_rsp_t: cursor_position, cell_char, scrolled
//   APB            in/out     psel/penable     prompt columns register at byte address 0
//
// A read reads the RAM when it is accepted and loads its result from S_READ, and a put
// applies the cursor update and cell write in S_PUT and loads its result from S_DONE.
// A put that scrolls first copies the rows up in S_COPY and then blanks the last row
// in S_FILL, one RAM word per cycle.
// After reset the screen RAM is filled with blanks, all COLUMNS*ROWS cells (2000 by
// default), before the first request is taken.
// A finished result waits in the output register; the next request is accepted
// meanwhile and stalls only when its own result is ready and the slot is full.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcw_req_t          in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tcw_rsp_t               out_rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CMP_W  = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [CH_W-1:0]     ch_q;
  logic                rd_ok_q, scr_q;
  logic                out_valid_q;
  tcw_rsp_t            out_q, out_d;
  logic                accept, slot_free, load, apply;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CH_W-1:0]     ram_wdata, ram_rdata;
  logic [CMP_W-1:0]    idx_ext;
  logic                in_range;
  logic [PROMPT_W-1:0] prompt;
  logic [ADDR_W-1:0]   cur_waddr;
  tcw_cur_sts_t        cur;

  // Configuration registers.
  tcw_apb u_apb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .prompt_o (prompt)
  );

  // Cursor and counters.
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .apply_i   (apply),
    .ch_i      (ch_q),
    .prompt_i  (prompt),
    .wr_addr_o (cur_waddr),
    .sts_o     (cur)
  );

  // Screen character store.
  tcw_ram #(
    .WIDTH (CH_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign idx_ext    = CMP_W'(in_req_i.cell_index);
  assign in_range   = idx_ext < CMP_W'(CELLS);

  // Request sequencer and RAM port control.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = CH_BLANK;
    ram_re    = 1'b0;
    ram_raddr = cnt_q + ADDR_W'(COLUMNS);
    apply     = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req_i.func == FUNC_READ) begin
            ram_re    = in_range;
            ram_raddr = idx_ext[ADDR_W-1:0];
            state_d   = S_READ;
          end else begin
            state_d = S_PUT;
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PUT: begin
        apply     = 1'b1;
        ram_we    = cur.cell_we;
        ram_waddr = cur_waddr;
        ram_wdata = cur.cell_data;
        if (cur.scroll) begin
          cnt_d   = '0;
          state_d = S_COPY;
        end else begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        // Read one row ahead and write the word read in the previous cycle.
        ram_re    = (cnt_q != COPY_LAST);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt_q == COPY_LAST) begin
          state_d = S_FILL;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result assembly.
  always_comb begin
    out_d.cursor_position = cur.position;
    out_d.cell_char       = ((state_q == S_READ) && rd_ok_q) ? ram_rdata : '0;
    out_d.scrolled        = (state_q == S_DONE) && scr_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q    <= in_req_i.ch;
      rd_ok_q <= in_range;
    end
    if (apply) begin
      scr_q <= cur.scroll;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_copy_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr < ram_raddr))
    else $error("row copy writes at or past the word it reads");

  a_dual_only_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (state_q == S_COPY))
    else $error("RAM read and write together outside the row copy");

  a_request_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ || state_q == S_PUT))
    else $error("accepted request did not start");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote one not yet taken");

endmodule

`default_nettype wire
